>>> rtl/core/stcdz_pkg.sv
package stcdz_pkg;

    localparam int SAMPLE_WIDTH  = 12;
    localparam int POS_WIDTH     = 12;
    localparam int NUM_WIDTH     = SAMPLE_WIDTH + POS_WIDTH;
    localparam int DIV_STEPS     = POS_WIDTH;
    localparam int S_TDATA_WIDTH = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int M_TDATA_WIDTH = ((POS_WIDTH + 7) / 8) * 8;
    localparam int ADDR_WIDTH    = 5;
    localparam int DZ_WIDTH      = 8;

    // register indexes (paddr[4:2])
    localparam logic [2:0] REG_RAW_MIN       = 3'd0;
    localparam logic [2:0] REG_RAW_MIDDLE    = 3'd1;
    localparam logic [2:0] REG_RAW_MAX       = 3'd2;
    localparam logic [2:0] REG_DEADZONE      = 3'd3;
    localparam logic [2:0] REG_THROTTLE_MODE = 3'd4;
    localparam logic [2:0] REG_REVERSED      = 3'd5;

    localparam logic [SAMPLE_WIDTH-1:0] RAW_MIN_RESET    = '0;
    localparam logic [SAMPLE_WIDTH-1:0] RAW_MIDDLE_RESET = SAMPLE_WIDTH'(2048);
    localparam logic [SAMPLE_WIDTH-1:0] RAW_MAX_RESET    = SAMPLE_WIDTH'(4095);
    localparam logic [DZ_WIDTH-1:0]     DEADZONE_RESET   = DZ_WIDTH'(25);

    localparam logic [POS_WIDTH-1:0] POS_CENTRE     = POS_WIDTH'(2048);
    localparam logic [POS_WIDTH-1:0] POS_FULL       = POS_WIDTH'(4095);
    localparam logic [POS_WIDTH-1:0] POS_UPPER_BASE = POS_WIDTH'(2047);

    typedef struct packed {
        logic [SAMPLE_WIDTH-1:0] raw_min;
        logic [SAMPLE_WIDTH-1:0] raw_middle;
        logic [SAMPLE_WIDTH-1:0] raw_max;
        logic [DZ_WIDTH-1:0]     deadzone;
        logic                    throttle_mode;
        logic                    reversed;
    } cfg_t;

    typedef struct packed {
        logic fault;       // calibration invalid, force centre
        logic centre;      // sample inside deadzone band
        logic upper_half;  // add the upper base to the quotient
        logic reversed;    // mirror the result
    } ctl_t;

    typedef struct packed {
        ctl_t                    ctl;
        logic [SAMPLE_WIDTH-1:0] den;
        logic [SAMPLE_WIDTH-1:0] rem;
        logic [POS_WIDTH-1:0]    qn;   // numerator bits out at top, quotient bits in at bottom
    } div_t;

endpackage

>>> rtl/core/stick_calibrated_deadzone_map_unit.sv
// Calibrated stick map. Each raw converter sample on the slave stream is
// clamped to the calibrated range and mapped to a 12-bit position: a linear
// 0..4095 ramp in throttle mode, or a centred stick in which a deadzone band
// around the middle gives 2048, the lower half ramps 0..2048 and the upper
// half 2047..4095; the reverse option mirrors to 4095 minus the value. A bad
// calibration (min not below max, middle not below max, or in centred mode an
// empty half range after the deadzone) returns 2048 with the fault flag set.
// One sample is taken every cycle while the output buffer has room; each result
// passes one set-up stage, twelve divider cells that each produce one quotient
// bit, and one output register.
// A two-entry output buffer lets the chain run on while a result waits.
// Program the calibration over APB only while no transfer is in flight.
module stick_calibrated_deadzone_map_unit (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // slave stream
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [stcdz_pkg::S_TDATA_WIDTH-1:0]   s_tdata,  // [11:0] raw_sample
    // master stream
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [stcdz_pkg::M_TDATA_WIDTH-1:0]   m_tdata,  // [11:0] position
    output logic [0:0]                            m_tuser,  // [0] calibration_fault
    // APB configuration
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [stcdz_pkg::ADDR_WIDTH-1:0]      paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready
);

    localparam int SW    = stcdz_pkg::SAMPLE_WIDTH;
    localparam int PW    = stcdz_pkg::POS_WIDTH;
    localparam int DZW   = stcdz_pkg::DZ_WIDTH;
    localparam int STEPS = stcdz_pkg::DIV_STEPS;

    stcdz_pkg::cfg_t cfg_reg;
    logic            wr_en;
    logic [2:0]      reg_idx;
    logic            en;

    logic            chain_valid [STEPS+1];
    stcdz_pkg::div_t chain_data  [STEPS+1];

    logic [PW-1:0]   position;
    logic            fault;

    // Configuration: write on the access phase, reads are combinational.
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.raw_min       <= stcdz_pkg::RAW_MIN_RESET;
            cfg_reg.raw_middle    <= stcdz_pkg::RAW_MIDDLE_RESET;
            cfg_reg.raw_max       <= stcdz_pkg::RAW_MAX_RESET;
            cfg_reg.deadzone      <= stcdz_pkg::DEADZONE_RESET;
            cfg_reg.throttle_mode <= 1'b0;
            cfg_reg.reversed      <= 1'b0;
        end else if (wr_en) begin
            unique case (reg_idx)
                stcdz_pkg::REG_RAW_MIN:       cfg_reg.raw_min       <= pwdata[SW-1:0];
                stcdz_pkg::REG_RAW_MIDDLE:    cfg_reg.raw_middle    <= pwdata[SW-1:0];
                stcdz_pkg::REG_RAW_MAX:       cfg_reg.raw_max       <= pwdata[SW-1:0];
                stcdz_pkg::REG_DEADZONE:      cfg_reg.deadzone      <= pwdata[DZW-1:0];
                stcdz_pkg::REG_THROTTLE_MODE: cfg_reg.throttle_mode <= pwdata[0];
                stcdz_pkg::REG_REVERSED:      cfg_reg.reversed      <= pwdata[0];
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            stcdz_pkg::REG_RAW_MIN:       prdata = {{(32 - SW){1'b0}}, cfg_reg.raw_min};
            stcdz_pkg::REG_RAW_MIDDLE:    prdata = {{(32 - SW){1'b0}}, cfg_reg.raw_middle};
            stcdz_pkg::REG_RAW_MAX:       prdata = {{(32 - SW){1'b0}}, cfg_reg.raw_max};
            stcdz_pkg::REG_DEADZONE:      prdata = {{(32 - DZW){1'b0}}, cfg_reg.deadzone};
            stcdz_pkg::REG_THROTTLE_MODE: prdata = {31'b0, cfg_reg.throttle_mode};
            stcdz_pkg::REG_REVERSED:      prdata = {31'b0, cfg_reg.reversed};
            default:                      prdata = '0;
        endcase
    end

    // The whole chain advances together; it holds only while the output
    // buffer is full, so s_tready comes straight from a register.
    assign s_tready = en;

    // Set-up stage: clamp, check calibration, pick numerator and divisor.
    stcdz_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .sample    (s_tdata[SW-1:0]),
        .cfg       (cfg_reg),
        .out_valid (chain_valid[0]),
        .out_data  (chain_data[0])
    );

    // Divider chain: each cell resolves one quotient bit, MSB first.
    for (genvar i = 0; i < STEPS; i++) begin : g_cell
        stcdz_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (chain_valid[i]),
            .in_data   (chain_data[i]),
            .out_valid (chain_valid[i+1]),
            .out_data  (chain_data[i+1])
        );
    end

    // Finish the position and hold it for the master side.
    stcdz_out u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (chain_valid[STEPS]),
        .in_data    (chain_data[STEPS]),
        .en         (en),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_position (position),
        .m_fault    (fault)
    );

    assign m_tdata = {{(stcdz_pkg::M_TDATA_WIDTH - PW){1'b0}}, position};
    assign m_tuser = fault;

endmodule

>>> rtl/core/stcdz_prep.sv
module stcdz_prep (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic [stcdz_pkg::SAMPLE_WIDTH-1:0] sample,
    input  stcdz_pkg::cfg_t                   cfg,
    output logic                              out_valid,
    output stcdz_pkg::div_t                   out_data
);

    localparam int SW = stcdz_pkg::SAMPLE_WIDTH;
    localparam int PW = stcdz_pkg::POS_WIDTH;
    localparam int NW = stcdz_pkg::NUM_WIDTH;
    localparam int EW = SW + 2;

    logic                  valid_reg;
    logic                  valid_next;
    stcdz_pkg::div_t       data_reg;
    stcdz_pkg::div_t       data_next;

    logic [SW-1:0]         s_clamp;
    logic [SW-1:0]         s_lo;
    logic [SW-1:0]         s_up;
    logic signed [EW-1:0]  lo_e, mid_e, hi_e, dz_e, s_e;
    logic signed [EW-1:0]  lower_e, upper_e, band_lo_e, band_hi_e, s_up_e;
    logic                  base_bad;
    logic                  half_bad;
    logic                  in_band;
    logic                  below;
    logic [NW-1:0]         num;

    always_comb begin
        s_clamp = sample;
        if (sample < cfg.raw_min) begin
            s_clamp = cfg.raw_min;
        end
        if (s_clamp > cfg.raw_max) begin
            s_clamp = cfg.raw_max;
        end

        lo_e  = $signed({2'b00, cfg.raw_min});
        mid_e = $signed({2'b00, cfg.raw_middle});
        hi_e  = $signed({2'b00, cfg.raw_max});
        dz_e  = $signed({{(EW - stcdz_pkg::DZ_WIDTH){1'b0}}, cfg.deadzone});
        s_e   = $signed({2'b00, s_clamp});

        lower_e   = mid_e - lo_e - dz_e;
        upper_e   = hi_e - mid_e - dz_e;
        band_lo_e = mid_e - dz_e;
        band_hi_e = mid_e + dz_e;
        s_up_e    = s_e - band_hi_e;

        base_bad = (cfg.raw_min >= cfg.raw_max) || (cfg.raw_middle >= cfg.raw_max);
        half_bad = (lower_e <= 0) || (upper_e <= 0);
        in_band  = (s_e > band_lo_e) && (s_e <= band_hi_e);
        below    = (s_e <= band_lo_e);

        s_lo = s_clamp - cfg.raw_min;
        s_up = s_up_e[SW-1:0];

        data_next = '0;
        data_next.ctl.reversed = cfg.reversed;
        if (cfg.throttle_mode) begin
            // full scale gain is 2^PW - 1
            data_next.ctl.fault = base_bad;
            num = {s_lo, {PW{1'b0}}} - {{PW{1'b0}}, s_lo};
            data_next.den = cfg.raw_max - cfg.raw_min;
        end else begin
            data_next.ctl.fault  = base_bad || half_bad;
            data_next.ctl.centre = in_band;
            data_next.ctl.upper_half = !below;
            // half scale gain is 2^(PW-1)
            if (below) begin
                num = {1'b0, s_lo, {(PW - 1){1'b0}}};
                data_next.den = lower_e[SW-1:0];
            end else begin
                num = {1'b0, s_up, {(PW - 1){1'b0}}};
                data_next.den = upper_e[SW-1:0];
            end
        end
        data_next.rem = num[NW-1:PW];
        data_next.qn  = num[PW-1:0];
        valid_next    = in_valid;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> rtl/core/stcdz_div_cell.sv
module stcdz_div_cell (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_valid,
    input  stcdz_pkg::div_t in_data,
    output logic            out_valid,
    output stcdz_pkg::div_t out_data
);

    localparam int SW = stcdz_pkg::SAMPLE_WIDTH;
    localparam int PW = stcdz_pkg::POS_WIDTH;

    logic            valid_reg;
    stcdz_pkg::div_t data_reg;
    stcdz_pkg::div_t data_next;
    logic [SW:0]     trial;
    logic [SW:0]     diff;
    logic            fits;

    // one restoring step: bring down the next numerator bit, subtract if it fits
    always_comb begin
        trial     = {in_data.rem, in_data.qn[PW-1]};
        diff      = trial - {1'b0, in_data.den};
        fits      = (trial >= {1'b0, in_data.den});
        data_next = in_data;
        data_next.rem = fits ? diff[SW-1:0] : trial[SW-1:0];
        data_next.qn  = {in_data.qn[PW-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> rtl/core/stcdz_out.sv
module stcdz_out (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    input  stcdz_pkg::div_t                in_data,
    output logic                           en,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [stcdz_pkg::POS_WIDTH-1:0] m_position,
    output logic                           m_fault
);

    localparam int PW = stcdz_pkg::POS_WIDTH;

    logic          out_valid_reg, out_valid_next;
    logic          skid_valid_reg, skid_valid_next;
    logic [PW-1:0] out_pos_reg, out_pos_next;
    logic          out_fault_reg, out_fault_next;
    logic [PW-1:0] skid_pos_reg, skid_pos_next;
    logic          skid_fault_reg, skid_fault_next;
    logic [PW-1:0] res_pos;
    logic [PW-1:0] ramp;
    logic          take;
    logic          out_free;

    // finish the result: add upper base, mirror, or force centre
    always_comb begin
        ramp = in_data.qn + (in_data.ctl.upper_half ? stcdz_pkg::POS_UPPER_BASE : '0);
        if (in_data.ctl.fault || in_data.ctl.centre) begin
            res_pos = stcdz_pkg::POS_CENTRE;
        end else if (in_data.ctl.reversed) begin
            res_pos = stcdz_pkg::POS_FULL - ramp;
        end else begin
            res_pos = ramp;
        end
    end

    assign en       = !skid_valid_reg;
    assign take     = in_valid && en;
    assign out_free = !out_valid_reg || m_ready;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_pos_next    = out_pos_reg;
        out_fault_next  = out_fault_reg;
        skid_valid_next = skid_valid_reg;
        skid_pos_next   = skid_pos_reg;
        skid_fault_next = skid_fault_reg;
        if (out_free) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_pos_next    = skid_pos_reg;
                out_fault_next  = skid_fault_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = take;
                out_pos_next   = res_pos;
                out_fault_next = in_data.ctl.fault;
            end
        end else if (take) begin
            skid_valid_next = 1'b1;
            skid_pos_next   = res_pos;
            skid_fault_next = in_data.ctl.fault;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_pos_reg    <= out_pos_next;
        out_fault_reg  <= out_fault_next;
        skid_pos_reg   <= skid_pos_next;
        skid_fault_reg <= skid_fault_next;
    end

    assign m_valid    = out_valid_reg;
    assign m_position = out_pos_reg;
    assign m_fault    = out_fault_reg;

endmodule

>>> verif/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import stcdz_pkg::*;

    // Pipeline depth from the block header: set-up stage, twelve divider cells,
    // output register.
    localparam int LATENCY      = 14;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int HOLD_CYCLES  = 80;
    localparam int RAND_PHASES  = 12;
    localparam int PHASE_ITEMS  = 120;

    // Mapping constants in signed integer form for the predictor.
    localparam int FULL_SCALE   = POS_FULL;
    localparam int UPPER_BASE   = POS_UPPER_BASE;
    localparam int HALF_SPAN    = 2048;
    localparam int SAMPLE_TOP   = (1 << SAMPLE_WIDTH) - 1;

    // Register index past the end of the map; writes to it must be dropped.
    localparam logic [2:0] REG_SPARE = 3'd7;

    // One mapped result: tdata position plus the tuser fault flag.
    typedef struct packed {
        logic [POS_WIDTH-1:0] position;
        logic                 fault;
    } stick_pos_t;

    // One directed stimulus row. Rows with known set carry a typed-in result;
    // the rest are checked against the predictor.
    typedef struct {
        cfg_t                    cal;
        logic [SAMPLE_WIDTH-1:0] sample;
        bit                      known;
        stick_pos_t              result;
    } stick_row_t;

    logic                     aclk = 1'b0;
    logic                     aresetn;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [S_TDATA_WIDTH-1:0] s_tdata;
    logic                     m_tvalid;
    logic                     m_tready;
    logic [M_TDATA_WIDTH-1:0] m_tdata;
    logic [0:0]               m_tuser;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [ADDR_WIDTH-1:0]    paddr;
    logic [31:0]              pwdata;
    logic [31:0]              prdata;
    logic                     pready;

    // Calibration as the block should hold it, updated at each register write.
    cfg_t                     cal;
    // Results still owed by the block, oldest first.
    stick_pos_t               pending_positions[$];
    stick_row_t               stick_rows[$];

    // Side-band travelling with the sample on s_tdata: a typed-in result.
    bit                       row_known;
    stick_pos_t               row_result;

    int                       src_idle_pct;
    int                       snk_idle_pct;
    logic                     hold_req;
    int                       hold_left;
    int                       err_cnt;
    int                       cycle_cnt;

    stick_calibrated_deadzone_map_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Expected position for one raw sample under the current calibration.
    function automatic stick_pos_t predict_position(input logic [SAMPLE_WIDTH-1:0] smp);
        int         lo;
        int         mid;
        int         hi;
        int         dz;
        int         s;
        int         pos;
        int         lower;
        int         upper;
        stick_pos_t r;
        lo  = int'(cal.raw_min);
        mid = int'(cal.raw_middle);
        hi  = int'(cal.raw_max);
        dz  = int'(cal.deadzone);
        s   = int'(smp);
        r.position = POS_CENTRE;
        r.fault    = 1'b1;
        // Bad range in either mode: centre with the fault flag, no mirroring.
        if (lo >= hi || mid >= hi) return r;
        if (s < lo) s = lo;
        if (s > hi) s = hi;
        r.fault = 1'b0;
        if (cal.throttle_mode) begin
            pos = (s - lo) * FULL_SCALE / (hi - lo);
        end else begin
            lower = mid - lo - dz;
            upper = hi - mid - dz;
            // Deadzone eats a whole half range: treat as a bad calibration.
            if (lower <= 0 || upper <= 0) begin
                r.fault = 1'b1;
                return r;
            end
            // Inside the deadzone band: centre, reverse not applied.
            if (s > mid - dz && s <= mid + dz) return r;
            if (s <= mid - dz)
                pos = (s - lo) * HALF_SPAN / lower;
            else
                pos = UPPER_BASE + (s - mid - dz) * HALF_SPAN / upper;
        end
        if (pos < 0) pos = 0;
        if (pos > FULL_SCALE) pos = FULL_SCALE;
        if (cal.reversed) pos = FULL_SCALE - pos;
        r.position = pos[POS_WIDTH-1:0];
        return r;
    endfunction

    function automatic cfg_t make_cal(input int lo, input int mid, input int hi,
                                      input int dz, input bit thr, input bit rev);
        cfg_t c;
        c.raw_min       = lo[SAMPLE_WIDTH-1:0];
        c.raw_middle    = mid[SAMPLE_WIDTH-1:0];
        c.raw_max       = hi[SAMPLE_WIDTH-1:0];
        c.deadzone      = dz[DZ_WIDTH-1:0];
        c.throttle_mode = thr;
        c.reversed      = rev;
        return c;
    endfunction

    // Clamp a value into the sample range.
    function automatic logic [SAMPLE_WIDTH-1:0] to_sample(input int v);
        if (v < 0) v = 0;
        if (v > SAMPLE_TOP) v = SAMPLE_TOP;
        return v[SAMPLE_WIDTH-1:0];
    endfunction

    // Random calibration: fully random (mostly bad), well formed, or extreme.
    function automatic cfg_t random_calibration();
        int lo;
        int mid;
        int hi;
        case ($urandom_range(0, 3))
            0: return make_cal($urandom_range(0, SAMPLE_TOP), $urandom_range(0, SAMPLE_TOP),
                               $urandom_range(0, SAMPLE_TOP), $urandom_range(0, 255),
                               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            3: return make_cal(0, $urandom_range(0, SAMPLE_TOP), SAMPLE_TOP,
                               ($urandom_range(0, 1) != 0) ? 255 : 0,
                               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            default: begin
                lo  = $urandom_range(0, 1500);
                hi  = $urandom_range(2600, SAMPLE_TOP);
                mid = $urandom_range(lo + 300, hi - 300);
                return make_cal(lo, mid, hi, $urandom_range(0, 255),
                                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
        endcase
    endfunction

    // Random sample, biased toward the range ends and the band edges.
    function automatic logic [SAMPLE_WIDTH-1:0] random_sample();
        int mid;
        int dz;
        mid = int'(cal.raw_middle);
        dz  = int'(cal.deadzone);
        case ($urandom_range(0, 7))
            4: return to_sample(int'(cal.raw_min) + $urandom_range(0, 6) - 3);
            5: return to_sample(int'(cal.raw_max) + $urandom_range(0, 6) - 3);
            6: return to_sample((($urandom_range(0, 1) != 0) ? mid + dz : mid - dz)
                                + $urandom_range(0, 4) - 2);
            7: return ($urandom_range(0, 1) != 0) ? SAMPLE_TOP[SAMPLE_WIDTH-1:0] : '0;
            default: return SAMPLE_WIDTH'($urandom_range(0, SAMPLE_TOP));
        endcase
    endfunction

    // APB tasks start and end just after a falling edge. They leave psel high
    // so back-to-back accesses get a single assignment per step; apb_idle
    // closes the bus.
    task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (idx)
            REG_RAW_MIN:       cal.raw_min       = val[SAMPLE_WIDTH-1:0];
            REG_RAW_MIDDLE:    cal.raw_middle    = val[SAMPLE_WIDTH-1:0];
            REG_RAW_MAX:       cal.raw_max       = val[SAMPLE_WIDTH-1:0];
            REG_DEADZONE:      cal.deadzone      = val[DZ_WIDTH-1:0];
            REG_THROTTLE_MODE: cal.throttle_mode = val[0];
            REG_REVERSED:      cal.reversed      = val[0];
            default: ;
        endcase
        @(negedge aclk);
    endtask

    // Read one register back and compare with the calibration copy.
    task automatic check_reg(input logic [2:0] idx, input logic [31:0] want);
        logic [31:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        got = prdata;
        if (got !== want) begin
            $display("%0t register %0d readback: expected %0h actual %0h", $time, idx, want, got);
            err_cnt++;
        end
        @(negedge aclk);
    endtask

    task automatic apb_idle();
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic check_registers();
        check_reg(REG_RAW_MIN,       32'(cal.raw_min));
        check_reg(REG_RAW_MIDDLE,    32'(cal.raw_middle));
        check_reg(REG_RAW_MAX,       32'(cal.raw_max));
        check_reg(REG_DEADZONE,      32'(cal.deadzone));
        check_reg(REG_THROTTLE_MODE, 32'(cal.throttle_mode));
        check_reg(REG_REVERSED,      32'(cal.reversed));
        apb_idle();
    endtask

    // Drop valid and hold off until every owed result is back, then let the
    // pipeline run dry before anything else happens.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending_positions.size() != 0) @(negedge aclk);
        repeat (LATENCY + 4) @(negedge aclk);
    endtask

    // Load a full calibration while idle; poke the unused index with all ones
    // and read everything back to prove that write was dropped.
    task automatic program_calibration(input cfg_t c);
        wait_drained();
        apb_write(REG_RAW_MIN,       32'(c.raw_min));
        apb_write(REG_RAW_MIDDLE,    32'(c.raw_middle));
        apb_write(REG_RAW_MAX,       32'(c.raw_max));
        apb_write(REG_DEADZONE,      32'(c.deadzone));
        apb_write(REG_THROTTLE_MODE, 32'(c.throttle_mode));
        apb_write(REG_REVERSED,      32'(c.reversed));
        apb_write(REG_SPARE,         32'hFFFF_FFFF);
        check_registers();
    endtask

    // Offer one sample after a random gap and wait for its transfer. Valid
    // stays high on return; the next call either reloads data or drops it.
    task automatic send_sample(input logic [SAMPLE_WIDTH-1:0] smp, input bit known,
                               input stick_pos_t res);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid   <= 1'b1;
        s_tdata    <= S_TDATA_WIDTH'(smp);
        row_known  <= known;
        row_result <= res;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic add_row(input cfg_t c, input int smp, input bit known,
                           input int pos, input bit fault);
        stick_row_t r;
        r.cal             = c;
        r.sample          = smp[SAMPLE_WIDTH-1:0];
        r.known           = known;
        r.result.position = pos[POS_WIDTH-1:0];
        r.result.fault    = fault;
        stick_rows.push_back(r);
    endtask

    // Cycle counter and watchdog.
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("%0t timeout with %0d results outstanding", $time,
                     pending_positions.size());
            $display("stick_calibrated_deadzone_map_unit verification failed");
            $finish;
        end
    end

    // Receiver: random stalls, or a long hold-off when one is requested so
    // the pipeline and output buffer fill and s_tready drops.
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req) begin
            m_tready  <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_req  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    // Scoreboard: record the expectation for each input transfer, then check
    // each output transfer against the oldest one. Both in one process so the
    // order within the edge is fixed.
    always @(posedge aclk) begin
        stick_pos_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready)
                pending_positions.push_back(row_known ? row_result
                                            : predict_position(s_tdata[SAMPLE_WIDTH-1:0]));
            if (m_tvalid && m_tready) begin
                if (pending_positions.size() == 0) begin
                    $display("%0t unexpected result: position %0d fault %0b", $time,
                             m_tdata[POS_WIDTH-1:0], m_tuser[0]);
                    err_cnt++;
                end else begin
                    want = pending_positions.pop_front();
                    if (m_tdata[POS_WIDTH-1:0] !== want.position) begin
                        $display("%0t position mismatch: expected %0d actual %0d", $time,
                                 want.position, m_tdata[POS_WIDTH-1:0]);
                        err_cnt++;
                    end
                    if (m_tuser[0] !== want.fault) begin
                        $display("%0t fault mismatch: expected %0b actual %0b", $time,
                                 want.fault, m_tuser[0]);
                        err_cnt++;
                    end
                end
            end
        end
    end

    initial begin
        cfg_t reset_cal;
        cfg_t clamp_cal;
        cfg_t thr_cal;
        cfg_t wide_dz;
        stick_pos_t none;

        // Drive every input known from time zero; hold reset.
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        m_tready     = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        row_known    = 1'b0;
        row_result   = '0;
        hold_req     = 1'b0;
        hold_left    = 0;
        err_cnt      = 0;
        cycle_cnt    = 0;
        none         = '0;
        // Sender busy, receiver heavily stalled for the first third.
        src_idle_pct = 17;
        snk_idle_pct = 82;

        reset_cal = make_cal(RAW_MIN_RESET, RAW_MIDDLE_RESET, RAW_MAX_RESET,
                             DEADZONE_RESET, 1'b0, 1'b0);
        clamp_cal = make_cal(1000, 2000, 3000, 50, 1'b0, 1'b0);
        thr_cal   = make_cal(1000, 2000, 3000, 50, 1'b1, 1'b0);
        wide_dz   = make_cal(0, 2048, 4095, 255, 1'b0, 1'b0);
        cal       = reset_cal;

        // Directed table. Reset calibration: range ends and deadzone edges.
        add_row(reset_cal, 0,    1, 0,    0);
        add_row(reset_cal, 4095, 1, 4095, 0);
        add_row(reset_cal, 2048, 1, 2048, 0);
        add_row(reset_cal, 2073, 1, 2048, 0);
        add_row(reset_cal, 2023, 1, 2048, 0);
        add_row(reset_cal, 2074, 0, 0,    0);
        add_row(reset_cal, 1000, 0, 0,    0);
        // Samples outside the calibrated range clamp to its ends.
        add_row(clamp_cal, 0,    1, 0,    0);
        add_row(clamp_cal, 4095, 1, 4095, 0);
        // Reverse mirrors the ramp but not the deadzone centre.
        clamp_cal.reversed = 1'b1;
        add_row(clamp_cal, 0,    1, 4095, 0);
        add_row(clamp_cal, 4095, 1, 0,    0);
        add_row(clamp_cal, 2000, 1, 2048, 0);
        add_row(clamp_cal, 2500, 0, 0,    0);
        // Throttle: one linear ramp, plain and mirrored.
        add_row(thr_cal,   0,    1, 0,    0);
        add_row(thr_cal,   4095, 1, 4095, 0);
        add_row(thr_cal,   2000, 0, 0,    0);
        thr_cal.reversed = 1'b1;
        add_row(thr_cal,   1500, 0, 0,    0);
        // Bad calibrations: min not below max, middle not below max, empty
        // lower half, empty upper half.
        add_row(make_cal(3000, 1000, 3000, 0, 1'b1, 1'b0),  1234, 1, 2048, 1);
        add_row(make_cal(0, 4095, 4095, 25, 1'b1, 1'b1),    4095, 1, 2048, 1);
        add_row(make_cal(1000, 1025, 3000, 25, 1'b0, 1'b1), 0,    1, 2048, 1);
        add_row(make_cal(0, 2000, 2100, 100, 1'b0, 1'b0),   2100, 1, 2048, 1);
        // Widest deadzone, and the narrowest throttle span at the top.
        add_row(wide_dz, 2303, 1, 2048, 0);
        add_row(wide_dz, 2304, 0, 0,    0);
        add_row(make_cal(4094, 0, 4095, 255, 1'b1, 1'b0), 4095, 1, 4095, 0);
        add_row(make_cal(4094, 0, 4095, 255, 1'b1, 1'b0), 0,    1, 0,    0);

        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        check_registers();

        // Walk the table; reprogram only where the calibration changes.
        foreach (stick_rows[i]) begin
            if (stick_rows[i].cal != cal) program_calibration(stick_rows[i].cal);
            send_sample(stick_rows[i].sample, stick_rows[i].known, stick_rows[i].result);
        end

        // Random phases, each under its own calibration. The first restores
        // reset values, the last spans the full range with the widest deadzone.
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            if (ph == RAND_PHASES / 3) begin
                src_idle_pct = 82;
                snk_idle_pct = 17;
            end else if (ph == 2 * RAND_PHASES / 3) begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            if (ph == 0)
                program_calibration(reset_cal);
            else if (ph == RAND_PHASES - 1)
                program_calibration(make_cal(0, $urandom_range(1, 4094), 4095, 255,
                                             1'($urandom_range(0, 1)),
                                             1'($urandom_range(0, 1))));
            else
                program_calibration(random_calibration());
            // Stall the receiver for a long stretch while samples keep coming.
            if (ph == 1) hold_req <= 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Pause the sender mid-phase until every result is back.
                if (ph == 5 && n == PHASE_ITEMS / 2) wait_drained();
                send_sample(random_sample(), 1'b0, none);
            end
        end

        wait_drained();
        if (err_cnt == 0 && pending_positions.size() == 0) begin
            $display("stick_calibrated_deadzone_map_unit verification clean");
        end else begin
            $display("stick_calibrated_deadzone_map_unit verification failed");
        end
        $finish;
    end

endmodule
